// ----- rtl/core/dfmt_pkg.sv -----
// Shared types and constants of the decimal digit field formatter.
package dfmt_pkg;

    localparam int COORD_W = 9;
    localparam int XPOS_W  = 10;
    localparam int VALUE_W = 32;
    localparam int DCNT_W  = 4;
    localparam int GLYPH_W = 6;
    localparam int CODE_W  = 7;
    localparam int STEP_W  = GLYPH_W - 1;

    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;

    localparam logic [COORD_W-1:0] SCREEN_WIDTH_RST  = 9'd240;
    localparam logic [COORD_W-1:0] SCREEN_HEIGHT_RST = 9'd240;

    localparam logic [CODE_W-1:0] CH_SPACE = 7'h20;
    localparam logic [CODE_W-1:0] CH_ZERO  = 7'h30;

    typedef struct packed {
        logic [COORD_W-1:0] x_start;
        logic [COORD_W-1:0] y_row;
        logic [VALUE_W-1:0] value;
        logic [DCNT_W-1:0]  digit_count;
        logic [GLYPH_W-1:0] glyph_height;
        logic               zero_pad;
    } dfmt_in_t;

    typedef struct packed {
        logic [CODE_W-1:0]  char_code;
        logic [XPOS_W-1:0]  x_pos;
        logic [COORD_W-1:0] y_pos;
        logic               rejected;
        logic               last;
    } dfmt_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dfmt_conv_stat_t;

endpackage

// ----- rtl/core/dfmt_bcd_conv.sv -----
// Iterative shift-and-add-3 binary to BCD converter, one bit per cycle.
module dfmt_bcd_conv #(
    parameter int DIGITS = 10
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [dfmt_pkg::VALUE_W-1:0] value,
    output dfmt_pkg::dfmt_conv_stat_t   stat,
    output logic [4*DIGITS-1:0]         bcd
);
    import dfmt_pkg::*;

    localparam int BCD_W = 4 * DIGITS;
    localparam int CNT_W = $clog2(VALUE_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_W - 1);

    logic [VALUE_W-1:0] bin_reg;
    logic [VALUE_W-1:0] bin_next;
    logic [BCD_W-1:0]   bcd_reg;
    logic [BCD_W-1:0]   bcd_next;
    logic [BCD_W-1:0]   corr;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic               busy_reg;
    logic               busy_next;
    logic               done;

    // add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                corr[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                corr[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    assign done = busy_reg && (cnt_reg == CNT_LAST);

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            bin_next  = value;
            bcd_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // the top digit carry drops out, which keeps the value modulo 10^DIGITS
            bcd_next = {corr[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (done)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign bcd       = bcd_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done;

endmodule

// ----- rtl/core/decimal_digit_field_formatter.sv -----
// Decimal digit field formatter: one request in, one character result per digit position out,
// most significant digit first. An accepted request that passes the start point check is
// loaded, runs through the shift-and-add-3 converter (one bit of the value per cycle), then
// gives its results, one per digit position, while the output register is free; the digit
// count is capped at MAX_DIGITS. A request whose start point lies beyond screen_width or
// screen_height passes through the emit state and gives a single rejected result once the
// output register is free. A request with a digit count of zero gives no result.
// While a request is at work in_stall is high; the next request is taken as soon as the last
// result sits in the output register. screen_width and screen_height come up as 240 and are
// written through cfg_we.
module decimal_digit_field_formatter #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  dfmt_pkg::dfmt_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output dfmt_pkg::dfmt_out_t            out_data,
    input  logic                           cfg_we,
    input  logic [dfmt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [dfmt_pkg::COORD_W-1:0]   cfg_data
);
    import dfmt_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [DCNT_W-1:0] LEN_MAX = DCNT_W'(MAX_DIGITS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    logic [COORD_W-1:0]  scr_w_reg;
    logic [COORD_W-1:0]  scr_h_reg;

    logic [XPOS_W-1:0]   x_reg;
    logic [XPOS_W-1:0]   x_next;
    logic [COORD_W-1:0]  y_reg;
    logic [COORD_W-1:0]  y_next;
    logic [STEP_W-1:0]   step_reg;
    logic [STEP_W-1:0]   step_next;
    logic                pad_reg;
    logic                pad_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [IDX_W-1:0]    idx_next;
    logic                shown_reg;
    logic                shown_next;
    logic                reject_reg;
    logic                reject_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    dfmt_out_t           out_data_reg;
    dfmt_out_t           out_data_next;

    logic                in_fire;
    logic                reject;
    logic [DCNT_W-1:0]   len;
    logic                conv_start;
    logic                slot_free;
    logic                emit_load;
    logic                blank;
    logic [3:0]          digit;
    logic [3:0]          digits [MAX_DIGITS];
    logic [4*MAX_DIGITS-1:0] bcd;
    dfmt_conv_stat_t     conv_stat;

    dfmt_bcd_conv #(
        .DIGITS (MAX_DIGITS)
    ) u_conv (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_start),
        .value (in_data.value),
        .stat  (conv_stat),
        .bcd   (bcd)
    );

    for (genvar g = 0; g < MAX_DIGITS; g++)
    begin : g_digit
        assign digits[g] = bcd[4*g +: 4];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scr_w_reg <= SCREEN_WIDTH_RST;
            scr_h_reg <= SCREEN_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  scr_w_reg <= cfg_data;
                REG_SCREEN_HEIGHT: scr_h_reg <= cfg_data;
                default:           ;
            endcase
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign in_fire    = in_valid && !in_stall;
    assign reject     = (in_data.x_start > scr_w_reg) || (in_data.y_row > scr_h_reg);
    assign len        = (in_data.digit_count > LEN_MAX) ? LEN_MAX : in_data.digit_count;
    assign conv_start = in_fire && !reject && (len != '0);

    assign slot_free = !out_valid_reg || !out_stall;
    assign emit_load = (state_reg == ST_EMIT) && slot_free;
    assign digit     = digits[idx_reg];
    // leading zero: nothing shown yet, not the last position
    assign blank     = !shown_reg && (idx_reg != '0) && (digit == 4'd0);

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        step_next      = step_reg;
        pad_next       = pad_reg;
        idx_next       = idx_reg;
        shown_next     = shown_reg;
        reject_next    = reject_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (!out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    x_next      = {1'b0, in_data.x_start};
                    y_next      = in_data.y_row;
                    step_next   = in_data.glyph_height[GLYPH_W-1:1];
                    pad_next    = in_data.zero_pad;
                    idx_next    = IDX_W'(len - 1'b1);
                    shown_next  = 1'b0;
                    reject_next = reject;
                    if (reject)
                        state_next = ST_EMIT;
                    else if (len != '0)
                        state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                if (conv_stat.done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    out_valid_next = 1'b1;
                    if (reject_reg)
                    begin
                        out_data_next = '0;
                        out_data_next.rejected = 1'b1;
                        out_data_next.last     = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        out_data_next.char_code = blank ? (pad_reg ? CH_ZERO : CH_SPACE)
                                                        : (CH_ZERO + {3'b000, digit});
                        out_data_next.x_pos     = x_reg;
                        out_data_next.y_pos     = y_reg;
                        out_data_next.rejected  = 1'b0;
                        out_data_next.last      = (idx_reg == '0);
                        if (!blank)
                            shown_next = 1'b1;
                        x_next   = x_reg + {{(XPOS_W-STEP_W){1'b0}}, step_reg};
                        idx_next = idx_reg - 1'b1;
                        if (idx_reg == '0)
                            state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        y_reg        <= y_next;
        step_reg     <= step_next;
        pad_reg      <= pad_next;
        idx_reg      <= idx_next;
        shown_reg    <= shown_next;
        reject_reg   <= reject_next;
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (reject || (len != '0))) |=> (state_reg != ST_IDLE))
        else $error("request with results accepted but sequencer stayed idle");

    a_done_in_conv: assert property (@(posedge clk) disable iff (!rst_n)
        conv_stat.done |-> (state_reg == ST_CONV))
        else $error("converter finished outside the conversion state");

    a_conv_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        conv_start |=> (conv_stat.busy && (state_reg == ST_CONV)))
        else $error("converter not running after start");

    a_reject_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.rejected) |-> out_data_reg.last)
        else $error("rejected result not marked last");

    a_last_ends_request: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && (reject_reg || (idx_reg == '0))) |=> (state_reg == ST_IDLE))
        else $error("sequencer kept running after the last result");

endmodule
